// ===== sv/urta_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urta_pkg: shared types and constants for the radix-to-ASCII converter
// Field widths, register indexes, divider handshake structs and the digit
// alphabet lookup.
// ----------------------------------------------------------------------------
package urta_pkg;

	// field and datapath widths
	localparam int VALUE_W     = 64;
	localparam int PREC_W      = 8;
	localparam int CHAR_W      = 8;
	localparam int RADIX_W     = 5;
	localparam int DIGIT_W     = 4;
	localparam int ALPHA_SIZE  = 16;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 64;

	// divider retires this many quotient bits per cycle
	localparam int DIV_BITS    = 8;
	localparam int DIV_STEPS   = VALUE_W / DIV_BITS;
	localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

	// digit store: at most one digit per value bit (radix two)
	localparam int DIG_DEPTH   = VALUE_W;
	localparam int DIG_ADDR_W  = $clog2(DIG_DEPTH);
	localparam int DIG_CNT_W   = DIG_ADDR_W + 1;

	// register reset values
	localparam logic [RADIX_W-1:0]    BASE_LENGTH_RST = 5'd10;
	localparam logic [CFG_DATA_W-1:0] CHARS_LOW_RST   = 64'h3736_3534_3332_3130;
	localparam logic [CFG_DATA_W-1:0] CHARS_HIGH_RST  = 64'h6665_6463_6261_3938;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BASE_LENGTH = 2'd0,
		REG_CHARS_LOW   = 2'd1,
		REG_CHARS_HIGH  = 2'd2
	} reg_index_t;

	// request into the shared divider
	typedef struct packed {
		logic                    start;
		logic [RADIX_W-1:0]      radix;
	} div_ctl_t;

	// status back from the shared divider
	typedef struct packed {
		logic                    done;
		logic [DIGIT_W-1:0]      rem;
	} div_sts_t;

	// ASCII code of one digit from the two alphabet words
	function automatic logic [CHAR_W-1:0] digit_code(
		input logic [DIGIT_W-1:0]    d,
		input logic [CFG_DATA_W-1:0] lo,
		input logic [CFG_DATA_W-1:0] hi
	);
		logic [CFG_DATA_W-1:0] word;
		word = d[DIGIT_W-1] ? hi : lo;
		return word[{d[DIGIT_W-2:0], 3'b000} +: CHAR_W];
	endfunction

endpackage

// ===== sv/urta_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urta_div: iterative divide of a 64-bit value by a small radix
// Restoring long division, DIV_BITS quotient bits per cycle; quotient and
// remainder are valid with the done pulse.
// ----------------------------------------------------------------------------
module urta_div
	import urta_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  div_ctl_t            ctl,
	input  logic [VALUE_W-1:0]  dividend,
	output div_sts_t            sts,
	output logic [VALUE_W-1:0]  quotient
);

	logic [VALUE_W-1:0]   acc_q;
	logic [DIGIT_W-1:0]   rem_q;
	logic [RADIX_W-1:0]   radix_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;

	logic [DIV_BITS-1:0]  qbits;
	logic [DIGIT_W-1:0]   rem_nxt;

	// one cycle of the division: DIV_BITS shift/compare/subtract steps
	always_comb begin
		logic [RADIX_W-1:0] t;
		rem_nxt = rem_q;
		qbits   = '0;
		for (int i = 0; i < DIV_BITS; i++) begin
			t = {rem_nxt, acc_q[VALUE_W-1-i]};
			if (t >= radix_q) begin
				t = t - radix_q;
				qbits[DIV_BITS-1-i] = 1'b1;
			end
			rem_nxt = t[DIGIT_W-1:0];
		end
	end

	// sequencing: quotient bits shift in where dividend bits leave
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				acc_q   <= dividend;
				rem_q   <= '0;
				radix_q <= ctl.radix;
				cnt_q   <= '0;
				busy_q  <= 1'b1;
			end else if (busy_q) begin
				acc_q <= {acc_q[VALUE_W-DIV_BITS-1:0], qbits};
				rem_q <= rem_nxt;
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign sts.done = done_q;
	assign sts.rem  = rem_q;
	assign quotient = acc_q;

endmodule

// ===== sv/unsigned_radix_to_ascii_precision_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unsigned_radix_to_ascii_precision_core: unsigned integer to ASCII digits
// Converts a 64-bit value to characters in a configurable radix and
// alphabet, most significant first, zero-padded to a printf precision.
// ----------------------------------------------------------------------------
// One request carries a 64-bit value and a signed precision (negative means
// one, capped at MAX_DIGITS). The value is split into digits by repeated
// division in a single shared divider, one division at a time; digits
// land in a 64-entry store and are then sent most significant first, one
// character per cycle while the receiver is ready, zero-padded to the
// precision, tlast on the final one. The slave side is not ready until the
// last character is in the output register. Zero with precision zero sends
// nothing. The radix is base_length clamped to 2..min(16, MAX_RADIX);
// config writes belong between requests.
// ----------------------------------------------------------------------------
module unsigned_radix_to_ascii_precision_core
	import urta_pkg::*;
#(
	parameter int MAX_RADIX  = 16,
	parameter int MAX_DIGITS = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration write port
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// request stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [71:0]           s_tdata,   // value [63:0], min_digits [71:64]
	// character stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [CHAR_W-1:0]     m_tdata,   // digit_char [7:0]
	output logic                  m_tlast
);

	localparam int RADIX_TOP = (MAX_RADIX < ALPHA_SIZE) ? MAX_RADIX : ALPHA_SIZE;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV,
		S_SETUP,
		S_RD,
		S_LOAD
	} state_t;

	state_t                 state_q;
	logic [RADIX_W-1:0]     base_length_q;
	logic [CFG_DATA_W-1:0]  chars_low_q;
	logic [CFG_DATA_W-1:0]  chars_high_q;
	logic [DIG_CNT_W-1:0]   ndig_q;
	logic [DIG_CNT_W-1:0]   prec_q;
	logic [DIG_ADDR_W-1:0]  pos_q;
	logic [DIGIT_W-1:0]     rd_q;
	logic [DIGIT_W-1:0]     dig_mem [DIG_DEPTH];
	logic                   m_tvalid_q;
	logic [CHAR_W-1:0]      out_char_q;
	logic                   out_last_q;

	logic [VALUE_W-1:0]     in_value;
	logic [PREC_W-1:0]      in_prec;
	logic                   accept;
	logic [RADIX_W-1:0]     eff_radix;
	logic [DIG_CNT_W-1:0]   prec_in;
	logic [DIG_CNT_W-1:0]   total;
	div_ctl_t               div_ctl;
	div_sts_t               div_sts;
	logic [VALUE_W-1:0]     div_quot;
	logic [VALUE_W-1:0]     div_dividend;
	logic                   quot_zero;
	logic                   out_free;
	logic                   rd_en;
	logic [DIG_ADDR_W-1:0]  rd_addr;
	logic                   pad;

	assign in_value = s_tdata[VALUE_W-1:0];
	assign in_prec  = s_tdata[VALUE_W+PREC_W-1:VALUE_W];
	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;

	// radix clamp
	always_comb begin
		eff_radix = base_length_q;
		if (eff_radix < RADIX_W'(2))
			eff_radix = RADIX_W'(2);
		if (eff_radix > RADIX_W'(RADIX_TOP))
			eff_radix = RADIX_W'(RADIX_TOP);
	end

	// precision: negative means one, capped at MAX_DIGITS
	always_comb begin
		if (in_prec[PREC_W-1])
			prec_in = DIG_CNT_W'(1);
		else if (in_prec > PREC_W'(MAX_DIGITS))
			prec_in = DIG_CNT_W'(MAX_DIGITS);
		else
			prec_in = in_prec[DIG_CNT_W-1:0];
	end

	assign total = (ndig_q > prec_q) ? ndig_q : prec_q;

	// shared divider
	assign quot_zero     = (div_quot == '0);
	assign div_dividend  = (state_q == S_IDLE) ? in_value : div_quot;
	assign div_ctl.radix = eff_radix;
	assign div_ctl.start = (accept && (in_value != '0)) ||
	                       ((state_q == S_DIV) && div_sts.done && !quot_zero);

	urta_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (div_ctl),
		.dividend (div_dividend),
		.sts      (div_sts),
		.quotient (div_quot)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_length_q <= BASE_LENGTH_RST;
			chars_low_q   <= CHARS_LOW_RST;
			chars_high_q  <= CHARS_HIGH_RST;
		end else if (cfg_we) begin
			case (reg_index_t'(cfg_index))
				REG_BASE_LENGTH: base_length_q <= cfg_data[RADIX_W-1:0];
				REG_CHARS_LOW:   chars_low_q   <= cfg_data;
				REG_CHARS_HIGH:  chars_high_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// digit store read side
	assign out_free = !m_tvalid_q || m_tready;
	assign rd_en    = (state_q == S_RD) ||
	                  ((state_q == S_LOAD) && out_free && (pos_q != '0));
	assign rd_addr  = (state_q == S_RD) ? pos_q : pos_q - 1'b1;
	assign pad      = ({1'b0, pos_q} >= ndig_q);

	// digit store: written by the divider, read for emission
	always_ff @(posedge clk) begin
		if ((state_q == S_DIV) && div_sts.done)
			dig_mem[ndig_q[DIG_ADDR_W-1:0]] <= div_sts.rem;
		if (rd_en)
			rd_q <= dig_mem[rd_addr];
	end

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			m_tvalid_q <= 1'b0;
			ndig_q     <= '0;
			prec_q     <= '0;
			pos_q      <= '0;
		end else begin
			if (m_tvalid_q && m_tready)
				m_tvalid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						prec_q  <= prec_in;
						ndig_q  <= '0;
						state_q <= (in_value == '0) ? S_SETUP : S_DIV;
					end
				end
				S_DIV: begin
					if (div_sts.done) begin
						ndig_q <= ndig_q + 1'b1;
						if (quot_zero)
							state_q <= S_SETUP;
					end
				end
				S_SETUP: begin
					if (total == '0) begin
						state_q <= S_IDLE;
					end else begin
						pos_q   <= DIG_ADDR_W'(total - 1'b1);
						state_q <= S_RD;
					end
				end
				S_RD: begin
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						out_char_q <= digit_code(pad ? DIGIT_W'(0) : rd_q,
						                         chars_low_q, chars_high_q);
						out_last_q <= (pos_q == '0);
						if (pos_q == '0)
							state_q <= S_IDLE;
						else
							pos_q <= pos_q - 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = out_char_q;
	assign m_tlast  = out_last_q;

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: regression bench for unsigned_radix_to_ascii_precision_core
// Sends value/precision requests under several radix and alphabet settings,
// predicts every digit character in the bench and checks the character
// stream in order, with bursty requests and a stalling receiver.
// ----------------------------------------------------------------------------
module tb;
	import urta_pkg::*;

	localparam int RADIX_CAP    = 16;
	localparam int DIGIT_CAP    = 64;
	localparam int SETTLE_CYC   = 80;
	localparam int STALL_LIMIT  = 4000;
	localparam int RAND_PER_SET = 37;

	// one expected character of the output stream
	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              last;
	} char_exp_t;

	logic                  clk;
	logic                  arst_n    = 1'b0;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_BASE_LENGTH;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [71:0]           s_tdata   = '0;   // value [63:0], min_digits [71:64]
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [CHAR_W-1:0]     m_tdata;          // digit_char [7:0]
	logic                  m_tlast;

	// bench copy of the register file
	logic [RADIX_W-1:0]    radix_reg;
	logic [CFG_DATA_W-1:0] alpha_lo;
	logic [CFG_DATA_W-1:0] alpha_hi;

	char_exp_t pending_chars[$];
	int        errors     = 0;
	int        burst_left = 4;
	int        idle_count = 0;

	unsigned_radix_to_ascii_precision_core #(
		.MAX_RADIX  (RADIX_CAP),
		.MAX_DIGITS (DIGIT_CAP)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// ASCII code of a digit from the bench alphabet
	function automatic logic [CHAR_W-1:0] alpha_char(input logic [DIGIT_W-1:0] d);
		logic [CFG_DATA_W-1:0] word;
		word = d[3] ? alpha_hi : alpha_lo;
		return CHAR_W'(word >> (d[2:0] * 8));
	endfunction

	// expected characters of one request, queued most significant first
	task automatic predict_chars(input logic [63:0] value, input logic [7:0] prec_raw);
		logic [63:0]  v;
		logic [63:0]  radix;
		logic [3:0]   digs[64];
		int           ndig;
		int           prec;
		int           total;
		int           pos;
		char_exp_t    e;
		radix = 64'(radix_reg);
		if (radix < 2)
			radix = 2;
		if (radix > RADIX_CAP)
			radix = RADIX_CAP;
		prec = prec_raw[7] ? 1 : int'(prec_raw);
		if (prec > DIGIT_CAP)
			prec = DIGIT_CAP;
		v    = value;
		ndig = 0;
		while (v != 0 && ndig < 64) begin
			digs[ndig] = 4'(v % radix);
			v          = v / radix;
			ndig++;
		end
		total = (ndig > prec) ? ndig : prec;
		for (int k = 0; k < total; k++) begin
			pos    = total - 1 - k;
			e.ch   = alpha_char((pos < ndig) ? digs[pos] : 4'd0);
			e.last = (k == total - 1);
			pending_chars.push_back(e);
		end
	endtask

	// send one request; the sender idles between bursts of random length
	task automatic send_request(input logic [63:0] value, input logic [7:0] prec_raw);
		s_tvalid <= 1'b1;
		s_tdata  <= {prec_raw, value};
		do
			@(posedge clk);
		while (!s_tready);
		predict_chars(value, prec_raw);
		burst_left--;
		if (burst_left <= 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 16);
		end
	endtask

	// quiet the request side and let every expected character arrive
	task automatic drain();
		if (s_tvalid)
			s_tvalid <= 1'b0;
		wait (pending_chars.size() == 0);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	// write all three registers back to back; block must be idle
	task automatic program_regs(input logic [4:0] base, input logic [63:0] lo,
			input logic [63:0] hi);
		drain();
		cfg_we    <= 1'b1;
		cfg_index <= REG_BASE_LENGTH;
		cfg_data  <= {$urandom, 27'($urandom), base};
		@(posedge clk);
		cfg_index <= REG_CHARS_LOW;
		cfg_data  <= lo;
		@(posedge clk);
		cfg_index <= REG_CHARS_HIGH;
		cfg_data  <= hi;
		@(posedge clk);
		cfg_we    <= 1'b0;
		radix_reg = base;
		alpha_lo  = lo;
		alpha_hi  = hi;
	endtask

	// value with a random bit length so digit counts spread out
	function automatic logic [63:0] rand_value();
		int          len;
		logic [63:0] v;
		len = $urandom_range(0, 64);
		v   = {$urandom, $urandom};
		if (len < 64)
			v &= (64'd1 << len) - 64'd1;
		return v;
	endfunction

	// mostly default or modest precision, some large, some out of range
	function automatic logic [7:0] rand_prec();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return 8'hFF;
			4, 5, 6:    return 8'($urandom_range(0, 12));
			7:          return 8'($urandom_range(13, 64));
			8:          return 8'd0;
			default:    return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// reset alphabet and radix ten: zero, precision limits, full range
	task automatic test_default_alphabet();
		send_request(64'd0, 8'd0);
		send_request(64'd0, 8'hFF);
		send_request(64'd0, 8'd1);
		send_request(64'd0, 8'd64);
		send_request(64'd1, 8'd0);
		send_request(64'd12345, 8'd8);
		send_request(64'hFFFF_FFFF_FFFF_FFFF, 8'hFF);
		send_request(64'hFFFF_FFFF_FFFF_FFFF, 8'd64);
		send_request(64'd9, 8'h80);
		send_request(64'd7, 8'd127);
		send_request(64'd42, 8'd65);
	endtask

	// radix clamping below two and above sixteen, plus both extremes
	task automatic test_radix_limits();
		program_regs(5'd0, 64'h3736_3534_3332_3130, 64'h4645_4443_4241_3938);
		send_request(64'hFFFF_FFFF_FFFF_FFFF, 8'hFF);
		send_request(64'd5, 8'd6);
		program_regs(5'd1, 64'h0000_0000_0000_5A41, 64'hFFFF_FFFF_FFFF_FFFF);
		send_request(64'h8000_0000_0000_0001, 8'hFF);
		program_regs(5'd17, 64'h3736_3534_3332_3130, 64'h4645_4443_4241_3938);
		send_request(64'hFEDC_BA98_7654_3210, 8'hFF);
		program_regs(5'd31, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0);
		send_request(64'hFFFF_FFFF_FFFF_FFFF, 8'd20);
		send_request(64'h0123_4567_89AB_CDEF, 8'd0);
		program_regs(5'd16, {$urandom, $urandom}, {$urandom, $urandom});
		send_request(64'hFEDC_BA98_7654_3210, 8'd1);
		program_regs(5'd2, 64'h3736_3534_3332_3130, 64'h6665_6463_6261_3938);
		send_request(64'd0, 8'd64);
	endtask

	// random requests under a run of register settings
	task automatic test_random_mix();
		logic [4:0] bases[7];
		bases = '{BASE_LENGTH_RST, 5'd2, 5'd16, 5'd0, 5'd31, 5'd3, 5'd7};
		for (int s = 0; s < 7; s++) begin
			if (s == 0)
				program_regs(bases[s], CHARS_LOW_RST, CHARS_HIGH_RST);
			else
				program_regs(bases[s], {$urandom, $urandom}, {$urandom, $urandom});
			for (int i = 0; i < RAND_PER_SET; i++)
				send_request(rand_value(), rand_prec());
		end
		program_regs(5'($urandom_range(3, 15)), {$urandom, $urandom},
			{$urandom, $urandom});
		for (int i = 0; i < RAND_PER_SET; i++)
			send_request(rand_value(), rand_prec());
	endtask

	// stimulus sequence
	initial begin
		radix_reg = BASE_LENGTH_RST;
		alpha_lo  = CHARS_LOW_RST;
		alpha_hi  = CHARS_HIGH_RST;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_alphabet();
		test_radix_limits();
		test_random_mix();
		drain();
		if (errors == 0)
			$display("unsigned_radix_to_ascii_precision_core regression: pass");
		else
			$display("unsigned_radix_to_ascii_precision_core regression: fail");
		$finish;
	end

	// receiver backpressure: the ready pattern switches among four modes at random
	initial begin : rx_stall
		int mode;
		int mode_left;
		int hold;
		mode      = 0;
		mode_left = 50;
		hold      = 0;
		forever begin
			@(posedge clk);
			if (mode_left == 0) begin
				mode      = $urandom_range(0, 3);
				mode_left = $urandom_range(20, 200);
			end else begin
				mode_left--;
			end
			case (mode)
				0: m_tready <= 1'b1;
				1: m_tready <= 1'($urandom_range(0, 1));
				2: m_tready <= ($urandom_range(0, 3) == 0);
				default: begin
					if (hold == 0) begin
						m_tready <= ~m_tready;
						hold = $urandom_range(1, 24);
					end else begin
						hold--;
					end
				end
			endcase
		end
	end

	// character checker against the oldest expectation
	always @(posedge clk) begin : char_check
		char_exp_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_chars.size() == 0) begin
				errors++;
				$display("%0t: unexpected character, expected none, actual %h last %b",
					$time, m_tdata, m_tlast);
			end else begin
				want = pending_chars.pop_front();
				if (m_tdata !== want.ch) begin
					errors++;
					$display("%0t: digit_char mismatch, expected %h, actual %h",
						$time, want.ch, m_tdata);
				end
				if (m_tlast !== want.last) begin
					errors++;
					$display("%0t: last mismatch, expected %b, actual %b",
						$time, want.last, m_tlast);
				end
			end
		end
	end

	// watchdog on cycles with no request and no character accepted
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_count <= 0;
		else if (idle_count >= STALL_LIMIT) begin
			$display("unsigned_radix_to_ascii_precision_core regression: fail");
			$finish;
		end else
			idle_count <= idle_count + 1;
	end

endmodule
